>>> hdl/isort_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package isort_pkg;

	localparam int CAPACITY = 64;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	typedef struct packed {
		logic signed [31:0] value;
		logic               last;
	} item_t;

	typedef struct packed {
		logic signed [31:0] sorted_value;
		logic               final_res;
		logic               overflow;
	} result_t;

	// per-cycle command broadcast to every cell of the chain
	typedef struct packed {
		logic ins;
		logic drain;
	} cell_ctl_t;

endpackage

`default_nettype wire

>>> hdl/insertion_sorter.sv
`timescale 1ns / 1ps
`default_nettype none

// Insertion sorter.
// Input channel: start/busy with item {value, last}. A beat is taken on a
// clock edge where start is high and busy is low; one beat per cycle while
// idle, since every cell compares against the new value and shifts at once.
// Each beat is inserted into a sorted chain of CAPACITY cells in ascending
// order; equal values keep their arrival order. Beats that arrive while the
// chain is full are dropped and flag overflow for the current list.
// A beat with last set is inserted, then the chain drains from cell 0:
// busy stays high until all stored elements have drained, and results appear
// with strobe on consecutive cycles, one per stored element: the edge that
// takes the last beat sets the drain state, then the output register loads.
// final_res marks the largest element; overflow is the same on every result
// of a list. Output is registered, so the next beat may be taken while the
// final result is shown. The receiver cannot stall: each result is valid
// for exactly one cycle.
// Reset empties the chain and clears the count and overflow flag at once.

module insertion_sorter (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	output logic                  busy,
	input  wire isort_pkg::item_t item,
	output logic                  strobe,
	output isort_pkg::result_t    result
);
	import isort_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EMIT = 1'b1;

	logic               state_q;
	logic [CNT_W-1:0]   fill_q;
	logic               dropped_q;
	logic               strobe_q;
	result_t            res_q;

	logic               accept;
	logic               full;
	cell_ctl_t          ctl;

	logic signed [31:0] val_w   [CAPACITY];
	logic               valid_w [CAPACITY];
	logic               gt_w    [CAPACITY];

	assign busy   = (state_q == ST_EMIT);
	assign accept = start && !busy;
	assign full   = (fill_q == CNT_W'(CAPACITY));

	assign ctl.ins   = accept && !full;
	assign ctl.drain = (state_q == ST_EMIT);

	genvar i;
	generate
		for (i = 0; i < CAPACITY; i++) begin : g_cell
			logic signed [31:0] lv;
			logic               lval;
			logic               lgt;
			logic signed [31:0] rv;
			logic               rval;

			if (i == 0) begin : g_first
				assign lv   = '0;
				assign lval = 1'b1;
				assign lgt  = 1'b0;
			end else begin : g_mid
				assign lv   = val_w[i-1];
				assign lval = valid_w[i-1];
				assign lgt  = gt_w[i-1];
			end

			if (i == CAPACITY - 1) begin : g_end
				assign rv   = '0;
				assign rval = 1'b0;
			end else begin : g_inner
				assign rv   = val_w[i+1];
				assign rval = valid_w[i+1];
			end

			isort_cell u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctl         (ctl),
				.din         (item.value),
				.left_val    (lv),
				.left_valid  (lval),
				.left_gt     (lgt),
				.right_val   (rv),
				.right_valid (rval),
				.val         (val_w[i]),
				.valid       (valid_w[i]),
				.gt          (gt_w[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			fill_q    <= '0;
			dropped_q <= 1'b0;
			strobe_q  <= 1'b0;
		end else begin
			strobe_q <= (state_q == ST_EMIT);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (full) begin
							dropped_q <= 1'b1;
						end else begin
							fill_q <= fill_q + CNT_W'(1);
						end
						if (item.last) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					fill_q <= fill_q - CNT_W'(1);
					if (fill_q == CNT_W'(1)) begin
						state_q   <= ST_IDLE;
						dropped_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT) begin
			res_q.sorted_value <= val_w[0];
			res_q.final_res    <= (fill_q == CNT_W'(1));
			res_q.overflow     <= dropped_q;
		end
	end

	assign strobe = strobe_q;
	assign result = res_q;

endmodule

`default_nettype wire

>>> hdl/isort_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module isort_cell (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire isort_pkg::cell_ctl_t ctl,
	input  wire logic signed [31:0]  din,
	input  wire logic signed [31:0]  left_val,
	input  wire logic                left_valid,
	input  wire logic                left_gt,
	input  wire logic signed [31:0]  right_val,
	input  wire logic                right_valid,
	output logic signed [31:0]       val,
	output logic                     valid,
	output logic                     gt
);
	import isort_pkg::*;

	logic signed [31:0] val_q;
	logic               valid_q;

	assign gt    = valid_q && (val_q > din);
	assign val   = val_q;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.drain) begin
			valid_q <= right_valid;
		end else if (ctl.ins) begin
			if (left_gt || gt || (!valid_q && left_valid)) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.drain) begin
			val_q <= right_val;
		end else if (ctl.ins) begin
			// larger values move one cell right; the new one lands at the boundary
			if (left_gt) begin
				val_q <= left_val;
			end else if (gt || (!valid_q && left_valid)) begin
				val_q <= din;
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/isort_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module isort_checker (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     start,
	input  wire                     busy,
	input  wire isort_pkg::item_t   item,
	input  wire                     strobe,
	input  wire isort_pkg::result_t result
);
	import isort_pkg::*;

	// a list beat with last set always starts a drain
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && item.last |=> busy)
		else $error("last beat did not start output");

	// results of one list come back to back
	a_contig: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.final_res |=> strobe)
		else $error("gap inside a result list");

	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.final_res |=> !strobe)
		else $error("result after final element");

	a_ovf_const: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.final_res |=> result.overflow == $past(result.overflow))
		else $error("overflow changed within a list");

	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("result without a drain in progress");

endmodule

bind insertion_sorter isort_checker u_isort_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.item   (item),
	.strobe (strobe),
	.result (result)
);

`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
	import isort_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int TAIL_CYCLES    = CAPACITY + 8;

	logic    clk    = 1'b0;
	logic    arst_n = 1'b0;
	logic    start  = 1'b0;
	item_t   item   = '0;
	logic    busy;
	logic    strobe;
	result_t result;

	insertion_sorter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.strobe (strobe),
		.result (result)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	item_t               beats_to_send[$];
	result_t             sorted_due[$];
	logic signed [31:0]  shadow_list[$];
	bit                  shadow_dropped = 1'b0;
	int unsigned         gap_left = 0;
	bit                  calm = 1'b0;
	int unsigned         n_bad = 0;
	int unsigned         idle_cycles = 0;
	int unsigned         n_random = 0;

	// Insert one beat into the shadow list; on last, queue the drained list.
	task automatic sort_insert(item_t it);
		logic signed [31:0] v;
		int                 pos;
		int                 n;
		v = it.value;
		if (shadow_list.size() < CAPACITY) begin
			pos = shadow_list.size();
			while (pos > 0 && shadow_list[pos - 1] > v)
				pos--;
			shadow_list.insert(pos, v);
		end else begin
			shadow_dropped = 1'b1;
		end
		if (it.last) begin
			n = shadow_list.size();
			for (int k = 0; k < n; k++)
				sorted_due.push_back(result_t'{sorted_value: shadow_list[k],
					final_res: (k == n - 1), overflow: shadow_dropped});
			shadow_list.delete();
			shadow_dropped = 1'b0;
		end
	endtask

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	function automatic logic signed [31:0] rand_value();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom;
			4, 5: return $signed($urandom_range(0, 8)) - 4;
			6: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
			7: return 32'sh7fff_ffff - $urandom_range(0, 3);
			8: return 32'sh8000_0000 + $urandom_range(0, 3);
			default: return $urandom_range(0, 1) ? 32'sh0 : -32'sh1;
		endcase
	endfunction

	task automatic add_beat(logic signed [31:0] v, logic l);
		beats_to_send.push_back(item_t'{value: v, last: l});
	endtask

	task automatic add_list(int len);
		for (int i = 0; i < len; i++)
			add_beat(rand_value(), i == len - 1);
		n_random += len;
	endtask

	task automatic report_bad(string what, result_t want, result_t got);
		n_bad++;
		if (n_bad <= 10)
			$display("%0t %s: want %0d/%b/%b got %0d/%b/%b", $realtime, what,
				want.sorted_value, want.final_res, want.overflow,
				got.sorted_value, got.final_res, got.overflow);
	endtask

	// driver: hold start while busy, otherwise count down the gap and present the next beat
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				sort_insert(item);
				void'(beats_to_send.pop_front());
				if ($urandom_range(0, 99) < 3)
					calm = !calm;
				gap_left = pick_gap();
			end
			if (start && busy) begin
				// beat not taken yet
			end else if (gap_left != 0 || beats_to_send.size() == 0) begin
				if (gap_left != 0)
					gap_left--;
				start <= 1'b0;
				item  <= {$urandom, 1'($urandom)};
			end else begin
				start <= 1'b1;
				item  <= beats_to_send[0];
			end
		end
	end

	// monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (strobe) begin
				if (sorted_due.size() == 0)
					report_bad("result with nothing due", '0, result);
				else begin
					result_t want;
					want = sorted_due.pop_front();
					if (result.sorted_value !== want.sorted_value)
						report_bad("sorted_value mismatch", want, result);
					else if (result.final_res !== want.final_res)
						report_bad("final_res mismatch", want, result);
					else if (result.overflow !== want.overflow)
						report_bad("overflow mismatch", want, result);
				end
			end
			if (strobe || (start && !busy))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		// extremes, mixed signs
		add_beat(32'sh7fff_ffff, 1'b0);
		add_beat(32'sh8000_0000, 1'b0);
		add_beat(32'sh0, 1'b0);
		add_beat(-32'sh1, 1'b0);
		add_beat(32'sh1, 1'b0);
		add_beat(32'sh0, 1'b1);
		// one-element list
		add_beat(32'sh8000_0000, 1'b1);
		// duplicates
		add_beat(32'sh3, 1'b0);
		add_beat(32'sh3, 1'b0);
		add_beat(-32'sh3, 1'b0);
		add_beat(32'sh3, 1'b0);
		add_beat(32'sh2, 1'b1);
		// descending input: every beat shifts the whole list
		for (int i = 4; i >= 0; i--)
			add_beat(i, i == 0);
		add_beat(32'sh5555_5555, 1'b0);
		add_beat(32'shaaaa_aaaa, 1'b1);
		// exactly full, then full with the last beat dropped
		add_list(CAPACITY);
		add_list(CAPACITY + 1);
		while (n_random < 400) begin
			case ($urandom_range(0, 9))
				0: add_list($urandom_range(CAPACITY - 4, CAPACITY + 12));
				1, 2: add_list($urandom_range(9, 40));
				default: add_list($urandom_range(1, 8));
			endcase
		end

		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		wait (beats_to_send.size() == 0);
		while (sorted_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (n_bad == 0 && sorted_due.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> insertion_sorter.f
hdl/isort_pkg.sv
hdl/isort_cell.sv
hdl/insertion_sorter.sv
hdl/isort_checker.sv
tb/sv/tb.sv
